FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When a holds at a clock edge, b must hold at the same edge.
`define ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// When a holds at a clock edge, b must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

FILE: rtl/dafp_pkg.sv
package dafp_pkg;

    localparam int COORD_BITS       = 20;
    localparam int ANGLE_ITERATIONS = 18;
    localparam int NUM_FIELDS       = 12;
    localparam int S_TDATA_W        = ((NUM_FIELDS * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W        = 16;

    // Bond vectors and their prescaled form.
    localparam int DIFF_W   = COORD_BITS + 1;
    localparam int VEC_BITS = 13;
    localparam int PV_W     = VEC_BITS + 1;
    localparam int CROSS_W  = 2 * PV_W;
    localparam int N_W      = 28;

    // Square root of |b2|^2 * 2^16.
    localparam int SQ_A_W   = 44;
    localparam int SQ_R_W   = 45;
    localparam int SQ_STEPS = 22;
    localparam int ROOT_W   = 23;

    // Triple product, cross dot and the atan2 operands.
    localparam int TP_W        = 44;
    localparam int CD_W        = 58;
    localparam int MAGC_W      = 56;
    localparam int WIDE_W      = 64;
    localparam int CORDIC_BITS = 30;
    localparam int NORM_STAGES = 3;

    // CORDIC datapath.
    localparam int XY_W    = 34;
    localparam int Z_W     = 44;
    localparam int SHIFT_W = 5;
    localparam int ZQ_W    = 28;

    localparam int DEG_W = 33;
    localparam logic [DEG_W-1:0] DEG_SCALE = 33'd6007897930;
    localparam logic [17:0] HALF_TURN = 18'd18000;

    // Cycles from an accepted item to its result in the output register.
    localparam int LAT = 34 + ANGLE_ITERATIONS;

    typedef struct packed {
        logic [SQ_A_W-1:0] rem;
        logic [SQ_R_W-1:0] root;
    } sqrt_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_t;

    typedef struct packed {
        logic zero;
        logic tneg;
        logic cneg;
    } flags_t;

    typedef logic signed [Z_W-1:0] angle_tab_t [ANGLE_ITERATIONS];

    // Long division by shift and subtract, evaluated while the table is built.
    function automatic logic [63:0] series_quotient(logic [63:0] a, logic [63:0] b);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], a[i]};
            if (r >= b)
            begin
                r = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/q) in Q60 from its alternating series.
    function automatic logic signed [63:0] atan_recip(logic [63:0] q);
        logic [63:0] term;
        logic [63:0] q2;
        logic [63:0] t;
        logic signed [63:0] sum;
        term = series_quotient(64'd1 << 60, q);
        q2   = q * q;
        sum  = '0;
        for (int k = 0; k < 40; k++)
        begin
            t = series_quotient(term, 64'(2 * k + 1));
            if (k % 2 == 1)
                sum = sum - $signed(t);
            else
                sum = sum + $signed(t);
            term = series_quotient(term, q2);
        end
        return sum;
    endfunction

    // Micro-rotation angles atan(2^-i) in Q40 radians.
    function automatic angle_tab_t build_angles();
        angle_tab_t tab;
        logic signed [63:0] v;
        for (int i = 0; i < ANGLE_ITERATIONS; i++)
        begin
            if (i == 0)
                v = atan_recip(64'd2) + atan_recip(64'd3);
            else
                v = atan_recip(64'd1 << i);
            v = (v + (64'sd1 <<< 19)) >>> 20;
            tab[i] = Z_W'(v);
        end
        return tab;
    endfunction

    localparam angle_tab_t ANGLE_TAB = build_angles();

endpackage

FILE: rtl/dafp_sqrt_cell.sv
module dafp_sqrt_cell (
    input  logic                         clk,
    input  logic                         ce,
    input  logic [dafp_pkg::SQ_A_W-1:0]  sq_bit,
    input  dafp_pkg::sqrt_t              d_in,
    output dafp_pkg::sqrt_t              d_out
);
    import dafp_pkg::*;

    sqrt_t             d_reg;
    sqrt_t             d_next;
    logic [SQ_R_W:0]   trial;

    // One result bit: subtract the trial value when it fits.
    always_comb
    begin
        trial = {1'b0, d_in.root} + (SQ_R_W + 1)'(sq_bit);
        if ((SQ_R_W + 1)'(d_in.rem) >= trial)
        begin
            d_next.rem  = d_in.rem - trial[SQ_A_W-1:0];
            d_next.root = (d_in.root >> 1) + SQ_R_W'(sq_bit);
        end
        else
        begin
            d_next.rem  = d_in.rem;
            d_next.root = d_in.root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            d_reg <= d_next;
    end

    assign d_out = d_reg;

endmodule

FILE: rtl/dafp_cordic_cell.sv
module dafp_cordic_cell (
    input  logic                               clk,
    input  logic                               ce,
    input  logic [dafp_pkg::SHIFT_W-1:0]       shift,
    input  logic signed [dafp_pkg::Z_W-1:0]    ang,
    input  dafp_pkg::cordic_t                  d_in,
    output dafp_pkg::cordic_t                  d_out
);
    import dafp_pkg::*;

    cordic_t                d_reg;
    cordic_t                d_next;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    // Vectoring micro-rotation that drives y toward zero.
    always_comb
    begin
        dx = d_in.y >>> shift;
        dy = d_in.x >>> shift;
        if (d_in.y > 0)
        begin
            d_next.x = d_in.x + dx;
            d_next.y = d_in.y - dy;
            d_next.z = d_in.z + ang;
        end
        else
        begin
            d_next.x = d_in.x - dx;
            d_next.y = d_in.y + dy;
            d_next.z = d_in.z - ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            d_reg <= d_next;
    end

    assign d_out = d_reg;

endmodule

FILE: rtl/dihedral_angle_from_four_points.sv
// Throughput: one item per cycle while the output does not stall, set by the fully
// pipelined root and CORDIC cells; a stall on the output freezes the whole pipeline.
// Reset: rst_n clears only the valid bits, so the pipeline comes up empty; payload
// registers are not reset.
module dihedral_angle_from_four_points (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from the lowest bit up: first_x, first_y, first_z, second_x, second_y,
    // second_z, third_x, third_y, third_z, fourth_x, fourth_y, fourth_z.
    input  logic [dafp_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from the lowest bit up: torsion.
    output logic [dafp_pkg::M_TDATA_W-1:0]  m_tdata
);
    import dafp_pkg::*;

    typedef struct packed {
        logic [TP_W-1:0]   mag_t;
        logic [MAGC_W-1:0] mag_c;
        logic              tneg;
        logic              cneg;
    } dly_t;

    localparam int DLY_LEN = SQ_STEPS - 2;

    // The whole pipeline advances together; it moves whenever the output
    // register is empty or being taken.
    logic ce;
    logic [LAT-1:0] vld_reg;

    assign ce       = m_tready || !vld_reg[LAT-1];
    assign s_tready = ce;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (ce)
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
    end

    // Stage 1: bond vectors b1, b2, b3.
    logic signed [COORD_BITS-1:0] pt [4][3];
    logic signed [DIFF_W-1:0]     s1_b_reg [3][3];

    always_comb
    begin
        for (int a = 0; a < 4; a++)
            for (int c = 0; c < 3; c++)
                pt[a][c] = $signed(s_tdata[(a * 3 + c) * COORD_BITS +: COORD_BITS]);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int v = 0; v < 3; v++)
                for (int c = 0; c < 3; c++)
                    s1_b_reg[v][c] <= DIFF_W'(pt[v+1][c]) - DIFF_W'(pt[v][c]);
        end
    end

    // Stage 2: scale each vector down by a power of two until all of its
    // magnitudes fit in 13 bits, truncating toward zero.
    logic signed [PV_W-1:0] s2_next [3][3];
    logic signed [PV_W-1:0] s2_reg  [3][3];

    always_comb
    begin
        logic [DIFF_W-1:0] mg [3];
        logic [DIFF_W-1:0] mx;
        logic [PV_W-1:0]   q;
        int                hb;
        int                sh;
        for (int v = 0; v < 3; v++)
        begin
            mx = '0;
            for (int c = 0; c < 3; c++)
            begin
                mg[c] = s1_b_reg[v][c][DIFF_W-1] ? DIFF_W'(-s1_b_reg[v][c])
                                                 : DIFF_W'(s1_b_reg[v][c]);
                if (mg[c] > mx)
                    mx = mg[c];
            end
            hb = 0;
            for (int k = 0; k < DIFF_W; k++)
                if (mx[k])
                    hb = k + 1;
            sh = (hb > VEC_BITS) ? hb - VEC_BITS : 0;
            for (int c = 0; c < 3; c++)
            begin
                q = PV_W'(mg[c] >> sh);
                s2_next[v][c] = s1_b_reg[v][c][DIFF_W-1] ? -$signed(q) : $signed(q);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            s2_reg <= s2_next;
    end

    // Stage 3: the partial products of both cross products and of |b2|^2.
    logic signed [CROSS_W-1:0] s3_m12a_reg [3];
    logic signed [CROSS_W-1:0] s3_m12b_reg [3];
    logic signed [CROSS_W-1:0] s3_m23a_reg [3];
    logic signed [CROSS_W-1:0] s3_m23b_reg [3];
    logic signed [CROSS_W-1:0] s3_sq_reg   [3];
    logic signed [PV_W-1:0]    s3_b1_reg   [3];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int c = 0; c < 3; c++)
            begin
                s3_m12a_reg[c] <= s2_reg[0][(c == 2) ? 0 : c + 1] * s2_reg[1][(c == 0) ? 2 : c - 1];
                s3_m12b_reg[c] <= s2_reg[0][(c == 0) ? 2 : c - 1] * s2_reg[1][(c == 2) ? 0 : c + 1];
                s3_m23a_reg[c] <= s2_reg[1][(c == 2) ? 0 : c + 1] * s2_reg[2][(c == 0) ? 2 : c - 1];
                s3_m23b_reg[c] <= s2_reg[1][(c == 0) ? 2 : c - 1] * s2_reg[2][(c == 2) ? 0 : c + 1];
                s3_sq_reg[c]   <= s2_reg[1][c] * s2_reg[1][c];
                s3_b1_reg[c]   <= s2_reg[0][c];
            end
        end
    end

    // Stage 4: b1 x b2, b2 x b3 and |b2|^2.
    logic signed [CROSS_W-1:0] s4_c12_reg [3];
    logic signed [CROSS_W-1:0] s4_c23_reg [3];
    logic signed [PV_W-1:0]    s4_b1_reg  [3];
    logic [N_W-1:0]            s4_n_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int c = 0; c < 3; c++)
            begin
                s4_c12_reg[c] <= s3_m12a_reg[c] - s3_m12b_reg[c];
                s4_c23_reg[c] <= s3_m23a_reg[c] - s3_m23b_reg[c];
                s4_b1_reg[c]  <= s3_b1_reg[c];
            end
            s4_n_reg <= N_W'(s3_sq_reg[0]) + N_W'(s3_sq_reg[1]) + N_W'(s3_sq_reg[2]);
        end
    end

    // Square root chain: one cell per result bit, fed from stage 4.
    sqrt_t sq_chain [SQ_STEPS+1];

    assign sq_chain[0].rem  = {s4_n_reg, 16'd0};
    assign sq_chain[0].root = '0;

    for (genvar g = 0; g < SQ_STEPS; g++)
    begin : g_sqrt
        dafp_sqrt_cell u_cell (
            .clk    (clk),
            .ce     (ce),
            .sq_bit (SQ_A_W'(1) << (2 * (SQ_STEPS - 1 - g))),
            .d_in   (sq_chain[g]),
            .d_out  (sq_chain[g+1])
        );
    end

    // Stage 5: products for the triple product and the cross dot.
    logic signed [TP_W-2:0] s5_pt_reg [3];
    logic signed [CD_W-3:0] s5_pc_reg [3];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int c = 0; c < 3; c++)
            begin
                s5_pt_reg[c] <= s4_b1_reg[c] * s4_c23_reg[c];
                s5_pc_reg[c] <= s4_c12_reg[c] * s4_c23_reg[c];
            end
        end
    end

    // Stage 6: T = b1 . (b2 x b3) and C = (b1 x b2) . (b2 x b3).
    logic signed [TP_W-1:0] s6_tp_reg;
    logic signed [CD_W-1:0] s6_cd_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s6_tp_reg <= TP_W'(s5_pt_reg[0]) + TP_W'(s5_pt_reg[1]) + TP_W'(s5_pt_reg[2]);
            s6_cd_reg <= CD_W'(s5_pc_reg[0]) + CD_W'(s5_pc_reg[1]) + CD_W'(s5_pc_reg[2]);
        end
    end

    // Magnitudes and signs wait here until the root leaves its chain.
    dly_t dly_reg [DLY_LEN];
    dly_t dly_first;
    logic [CD_W-1:0] cd_mag;

    always_comb
    begin
        cd_mag              = s6_cd_reg[CD_W-1] ? CD_W'(-s6_cd_reg) : CD_W'(s6_cd_reg);
        dly_first.mag_t     = s6_tp_reg[TP_W-1] ? TP_W'(-s6_tp_reg) : TP_W'(s6_tp_reg);
        dly_first.mag_c     = cd_mag[MAGC_W-1:0];
        dly_first.tneg      = s6_tp_reg[TP_W-1];
        dly_first.cneg      = s6_cd_reg[CD_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dly_reg[0] <= dly_first;
            for (int k = 1; k < DLY_LEN; k++)
                dly_reg[k] <= dly_reg[k-1];
        end
    end

    // Stage 27: yy = |T| * |b2| * 2^8 as two partial products, xx = |C| * 2^8.
    logic [ROOT_W-1:0]       root;
    logic [TP_W/2+ROOT_W-1:0] s27_plo_reg;
    logic [TP_W/2+ROOT_W-1:0] s27_phi_reg;
    logic [WIDE_W-1:0]       s27_xx_reg;
    logic                    s27_tneg_reg;
    logic                    s27_cneg_reg;

    assign root = sq_chain[SQ_STEPS].root[ROOT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s27_plo_reg  <= dly_reg[DLY_LEN-1].mag_t[TP_W/2-1:0] * root;
            s27_phi_reg  <= dly_reg[DLY_LEN-1].mag_t[TP_W-1:TP_W/2] * root;
            s27_xx_reg   <= {dly_reg[DLY_LEN-1].mag_c, 8'd0};
            s27_tneg_reg <= dly_reg[DLY_LEN-1].tneg;
            s27_cneg_reg <= dly_reg[DLY_LEN-1].cneg;
        end
    end

    // Stage 28: finish yy and flag the case where both operands are zero.
    logic [WIDE_W-1:0] yy_next;
    logic [WIDE_W-1:0] s28_xx_reg;
    logic [WIDE_W-1:0] s28_yy_reg;
    flags_t            s28_fl_reg;

    assign yy_next = WIDE_W'(s27_plo_reg) + (WIDE_W'(s27_phi_reg) << (TP_W / 2));

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s28_xx_reg      <= s27_xx_reg;
            s28_yy_reg      <= yy_next;
            s28_fl_reg.zero <= (s27_xx_reg == '0) && (yy_next == '0);
            s28_fl_reg.tneg <= s27_tneg_reg;
            s28_fl_reg.cneg <= s27_cneg_reg;
        end
    end

    // Stages 29 to 31: shift both operands right by the smallest count that
    // brings them below 2^30, built up from shifts of 32, 16, 8, 4, 2 and 1.
    logic [WIDE_W-1:0] nx_reg [NORM_STAGES];
    logic [WIDE_W-1:0] ny_reg [NORM_STAGES];
    flags_t            nf_reg [NORM_STAGES];

    for (genvar g = 0; g < NORM_STAGES; g++)
    begin : g_norm
        logic [WIDE_W-1:0] x_in;
        logic [WIDE_W-1:0] y_in;
        logic [WIDE_W-1:0] x_n;
        logic [WIDE_W-1:0] y_n;
        flags_t            f_in;

        assign x_in = (g == 0) ? s28_xx_reg : nx_reg[(g == 0) ? 0 : g - 1];
        assign y_in = (g == 0) ? s28_yy_reg : ny_reg[(g == 0) ? 0 : g - 1];
        assign f_in = (g == 0) ? s28_fl_reg : nf_reg[(g == 0) ? 0 : g - 1];

        always_comb
        begin
            x_n = x_in;
            y_n = y_in;
            for (int h = 0; h < 2; h++)
            begin
                if ((x_n >> (CORDIC_BITS - 1 + (32 >> (2 * g + h)))) != '0 ||
                    (y_n >> (CORDIC_BITS - 1 + (32 >> (2 * g + h)))) != '0)
                begin
                    x_n = x_n >> (32 >> (2 * g + h));
                    y_n = y_n >> (32 >> (2 * g + h));
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                nx_reg[g] <= x_n;
                ny_reg[g] <= y_n;
                nf_reg[g] <= f_in;
            end
        end
    end

    // CORDIC chain: one cell per micro-rotation.
    cordic_t cd_chain [ANGLE_ITERATIONS+1];
    flags_t  fl_reg   [ANGLE_ITERATIONS];

    assign cd_chain[0].x = XY_W'(nx_reg[NORM_STAGES-1][CORDIC_BITS-1:0]);
    assign cd_chain[0].y = XY_W'(ny_reg[NORM_STAGES-1][CORDIC_BITS-1:0]);
    assign cd_chain[0].z = '0;

    for (genvar g = 0; g < ANGLE_ITERATIONS; g++)
    begin : g_cordic
        dafp_cordic_cell u_cell (
            .clk   (clk),
            .ce    (ce),
            .shift (SHIFT_W'(g)),
            .ang   (ANGLE_TAB[g]),
            .d_in  (cd_chain[g]),
            .d_out (cd_chain[g+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            fl_reg[0] <= nf_reg[NORM_STAGES-1];
            for (int k = 1; k < ANGLE_ITERATIONS; k++)
                fl_reg[k] <= fl_reg[k-1];
        end
    end

    // Stage 50: clamp the angle to the first quadrant, then reflect it when the
    // cross dot is negative, and keep it in Q26.
    logic signed [Z_W-1:0] z_fin;
    logic signed [Z_W-1:0] z_cl;
    logic [ZQ_W-1:0]       s50_zq_reg;
    flags_t                s50_fl_reg;

    always_comb
    begin
        z_fin = cd_chain[ANGLE_ITERATIONS].z;
        if (z_fin < 0)
            z_cl = '0;
        else if (z_fin > (ANGLE_TAB[0] <<< 1))
            z_cl = ANGLE_TAB[0] <<< 1;
        else
            z_cl = z_fin;
        if (fl_reg[ANGLE_ITERATIONS-1].cneg)
            z_cl = (ANGLE_TAB[0] <<< 2) - z_cl;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s50_zq_reg <= ZQ_W'(z_cl >>> 14);
            s50_fl_reg <= fl_reg[ANGLE_ITERATIONS-1];
        end
    end

    // Stage 51: conversion to hundredths of a degree as two partial products.
    logic [ZQ_W+16:0] s51_plo_reg;
    logic [ZQ_W+15:0] s51_phi_reg;
    flags_t           s51_fl_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s51_plo_reg <= s50_zq_reg * DEG_SCALE[16:0];
            s51_phi_reg <= s50_zq_reg * DEG_SCALE[DEG_W-1:17];
            s51_fl_reg  <= s50_fl_reg;
        end
    end

    // Output register: round half up, clamp, apply the sign of T, or give zero when both operands are zero.
    logic [WIDE_W-1:0]    prod;
    logic [17:0]          hund;
    logic [M_TDATA_W-1:0] torsion_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    always_comb
    begin
        prod = WIDE_W'(s51_plo_reg) + (WIDE_W'(s51_phi_reg) << 17);
        hund = 18'((prod + (WIDE_W'(1) << 45)) >> 46);
        if (hund > HALF_TURN)
            hund = HALF_TURN;
        if (s51_fl_reg.zero)
            torsion_next = '0;
        else if (s51_fl_reg.tneg)
            torsion_next = M_TDATA_W'(-hund);
        else
            torsion_next = M_TDATA_W'(hund);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            m_tdata_reg <= torsion_next;
    end

    assign m_tdata = m_tdata_reg;

endmodule

FILE: rtl/dafp_checker.sv
`include "assert_macros.svh"

module dafp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [dafp_pkg::M_TDATA_W-1:0] m_tdata
);
    import dafp_pkg::*;

    // A result that waits keeps its value.
    `ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Every result is a legal angle.
    `ASSERT_SAME(a_range, clk, rst_n, m_tvalid, ($signed(m_tdata) >= -16'sd18000) && ($signed(m_tdata) <= 16'sd18000))

    // The pipeline takes an item whenever its output side can move.
    `ASSERT_SAME(a_ready, clk, rst_n, !m_tvalid || m_tready, s_tready)

endmodule

bind dihedral_angle_from_four_points dafp_checker u_dafp_checker (.*);

FILE: dv/dihedral_angle_from_four_points_tb.sv
module dihedral_angle_from_four_points_tb;

    import dafp_pkg::*;

    typedef longint vec3_t [3];
    typedef logic [S_TDATA_W-1:0] quad_t;

    // One row of the directed table. Some rows whose torsion can be read straight off
    // the geometry have it typed in and flagged; every other row uses the predictor.
    typedef struct {
        longint pt [12];
        bit     known;
        int     torsion;
    } quad_row_t;

    localparam int NUM_ITEMS  = 750;
    localparam int LONG_HOLD  = 300;
    localparam int IDLE_LIMIT = 2000;
    localparam longint MAXC = 524287;
    localparam longint MINC = -524288;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    // Torsion values still to come out, oldest first.
    logic [15:0] torsion_q [$];
    longint      micro_rad [ANGLE_ITERATIONS];

    int  errors      = 0;
    int  sent        = 0;
    int  checked     = 0;
    bit  in_idle_en  = 1'b1;
    bit  out_idle_en = 1'b1;
    bit  hold_req    = 1'b0;
    int  quiet_cycles = 0;

    dihedral_angle_from_four_points dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // atan(1/q) in Q60 radians, summed from its alternating series.
    function automatic longint atan_inv_q60(longint unsigned q);
        longint unsigned term;
        longint unsigned q2;
        longint          t;
        longint          sum;
        term = (64'd1 << 60) / q;
        q2   = q * q;
        sum  = 0;
        for (int k = 0; k < 40; k++)
        begin
            t = longint'(term / longint'(2 * k + 1));
            sum = (k % 2 == 1) ? sum - t : sum + t;
            term = term / q2;
        end
        return sum;
    endfunction

    // Scale a bond down by a power of two until every component is below 8192,
    // truncating each magnitude toward zero.
    function automatic vec3_t shrink_bond(vec3_t v);
        longint unsigned biggest;
        longint unsigned m;
        int              s;
        vec3_t           o;
        biggest = 0;
        s = 0;
        for (int k = 0; k < 3; k++)
        begin
            m = (v[k] < 0) ? -v[k] : v[k];
            if (m > biggest)
                biggest = m;
        end
        while ((biggest >> s) >= 8192)
            s++;
        for (int k = 0; k < 3; k++)
        begin
            m = (v[k] < 0) ? -v[k] : v[k];
            m = m >> s;
            o[k] = (v[k] < 0) ? -longint'(m) : longint'(m);
        end
        return o;
    endfunction

    function automatic vec3_t cross_of(vec3_t a, vec3_t b);
        vec3_t o;
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
        return o;
    endfunction

    function automatic longint dot_of(vec3_t a, vec3_t b);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    // Exact integer square root, one result bit per pass.
    function automatic longint unsigned root_of(longint unsigned a);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++)
        begin
            if (a >= res + bitv)
            begin
                a   = a - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Expected torsion, in hundredths of a degree, for one packed quadruple.
    function automatic logic [15:0] torsion_of(quad_t d);
        longint          p [4][3];
        vec3_t           b1, b2, b3, c12, c23;
        longint          tp, cd, x, y, z, dx, dy, quarter, res;
        longint unsigned r, xx, yy, hund;
        int              sh;
        for (int a = 0; a < 4; a++)
            for (int j = 0; j < 3; j++)
                p[a][j] = longint'($signed(d[(a * 3 + j) * COORD_BITS +: COORD_BITS]));
        for (int j = 0; j < 3; j++)
        begin
            b1[j] = p[1][j] - p[0][j];
            b2[j] = p[2][j] - p[1][j];
            b3[j] = p[3][j] - p[2][j];
        end
        b1  = shrink_bond(b1);
        b2  = shrink_bond(b2);
        b3  = shrink_bond(b3);
        c12 = cross_of(b1, b2);
        c23 = cross_of(b2, b3);
        tp  = dot_of(b1, c23);
        cd  = dot_of(c12, c23);
        r   = root_of(longint'(dot_of(b2, b2)) << 16);
        yy  = ((tp < 0) ? -tp : tp) * r;
        xx  = ((cd < 0) ? -cd : cd) << 8;
        if (xx == 0 && yy == 0)
            return 16'd0;
        // Normalize both operands by one common shift so they fit the rotator.
        sh = 0;
        while ((xx >> sh) >= (64'd1 << 30) || (yy >> sh) >= (64'd1 << 30))
            sh++;
        x = longint'(xx >> sh);
        y = longint'(yy >> sh);
        z = 0;
        for (int i = 0; i < ANGLE_ITERATIONS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + micro_rad[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - micro_rad[i];
            end
        end
        quarter = micro_rad[0];
        if (z < 0)
            z = 0;
        if (z > 2 * quarter)
            z = 2 * quarter;
        if (cd < 0)
            z = 4 * quarter - z;
        hund = (longint'(z >>> 14) * 64'd6007897930 + (64'd1 << 45)) >> 46;
        if (hund > 18000)
            hund = 18000;
        res = (tp < 0) ? -longint'(hund) : longint'(hund);
        return res[15:0];
    endfunction

    function automatic quad_t pack_points(longint pt [12]);
        quad_t d;
        d = '0;
        for (int k = 0; k < 12; k++)
            d[k * COORD_BITS +: COORD_BITS] = pt[k][COORD_BITS-1:0];
        return d;
    endfunction

    function automatic longint rand_coord();
        return longint'($signed(20'($urandom)));
    endfunction

    function automatic longint rand_span(int span);
        return longint'($urandom_range(2 * span)) - span;
    endfunction

    // Random quadruple. Most are chains of bonds, usually short as in real structures;
    // the rest are raw bit patterns, extreme corners and collinear or coincident points.
    function automatic quad_t random_quad();
        longint pt [12];
        longint corner [5];
        longint dv [3];
        int     mode;
        int     step;
        corner = '{MINC, MAXC, 0, -1, 1};
        mode = $urandom_range(99);
        if (mode < 60)
        begin
            for (int j = 0; j < 3; j++)
                pt[j] = rand_span(200000);
            step = ($urandom_range(3) == 0) ? 60000 : 1000;
            for (int k = 3; k < 12; k++)
                pt[k] = pt[k - 3] + rand_span(step);
        end
        else if (mode < 80)
        begin
            for (int k = 0; k < 12; k++)
                pt[k] = rand_coord();
        end
        else if (mode < 90)
        begin
            for (int k = 0; k < 12; k++)
                pt[k] = corner[$urandom_range(4)];
        end
        else
        begin
            for (int j = 0; j < 3; j++)
            begin
                pt[j] = rand_span(100000);
                dv[j] = rand_span(3000);
            end
            step = $urandom_range(3);
            for (int j = 0; j < 3; j++)
            begin
                pt[3 + j] = pt[j] + dv[j];
                pt[6 + j] = pt[j] + 2 * dv[j];
                pt[9 + j] = pt[j] + longint'(step) * dv[j];
            end
        end
        return pack_points(pt);
    endfunction

    // Offer one item and hold it until the block takes it. Idle cycles, when
    // enabled, come before the item so that valid never drops while it waits.
    task automatic send_item(quad_t d, bit known, logic [15:0] torsion);
        while (in_idle_en && $urandom_range(99) < 31)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        torsion_q.insert(torsion_q.size(), known ? torsion : torsion_of(d));
        sent++;
    endtask

    // Receiver: random back-pressure, one long hold on request, and the check
    // of every item that leaves the block.
    initial
    begin : receiver
        logic [15:0] want;
        int          hold;
        m_tready = 1'b0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (torsion_q.size() == 0)
                begin
                    $display("%0t: torsion %0d arrived with none expected",
                             $time, $signed(m_tdata));
                    errors++;
                end
                else
                begin
                    want = torsion_q.pop_front();
                    if (m_tdata !== want)
                    begin
                        $display("%0t: torsion mismatch, expected %0d, actual %0d",
                                 $time, $signed(want), $signed(m_tdata));
                        errors++;
                    end
                    checked++;
                end
            end
            if (hold_req && hold == 0)
            begin
                hold = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(out_idle_en && $urandom_range(99) < 31);
        end
    end

    // Watchdog: the run is stuck when neither side moves an item for too long.
    initial
    begin : watchdog
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        quad_row_t rows [$];
        quad_row_t row;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        for (int i = 0; i < ANGLE_ITERATIONS; i++)
        begin
            if (i == 0)
                micro_rad[i] = (atan_inv_q60(2) + atan_inv_q60(3) + (64'sd1 <<< 19)) >>> 20;
            else
                micro_rad[i] = (atan_inv_q60(64'd1 << i) + (64'sd1 <<< 19)) >>> 20;
        end

        // Coincident points: both operands vanish, torsion is zero.
        rows.insert(rows.size(), '{'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, 0});
        // Collinear bonds are degenerate too.
        rows.insert(rows.size(), '{'{0, 0, 0, 256, 0, 0, 512, 0, 0, 768, 0, 0}, 1'b1, 0});
        rows.insert(rows.size(), '{'{MINC, MINC, MINC, 0, 0, 0, MAXC, MAXC, MAXC, 0, 0, 0},
                                   1'b1, 0});
        // Trans planar geometry: negative x, zero y gives exactly a half turn.
        rows.insert(rows.size(), '{'{0, 256, 0, 0, 0, 0, 256, 0, 0, 256, -256, 0},
                                   1'b1, 18000});
        // Planar geometry at the corners of the fields, both end points on one side.
        rows.insert(rows.size(), '{'{MINC, MAXC, 0, MINC, MINC, 0, MAXC, MINC, 0,
                                     MAXC, MAXC, 0}, 1'b0, 0});
        // Cis planar geometry, and the quarter turns in both senses.
        rows.insert(rows.size(), '{'{0, 256, 0, 0, 0, 0, 256, 0, 0, 256, 256, 0}, 1'b0, 0});
        rows.insert(rows.size(), '{'{0, 256, 0, 0, 0, 0, 256, 0, 0, 256, 0, 256}, 1'b0, 0});
        rows.insert(rows.size(), '{'{0, 256, 0, 0, 0, 0, 256, 0, 0, 256, 0, -256}, 1'b0, 0});
        // Long bonds that need prescaling, at the extremes of the fields.
        rows.insert(rows.size(), '{'{MINC, MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC, MINC,
                                     MAXC, MAXC, MAXC}, 1'b0, 0});
        rows.insert(rows.size(), '{'{MAXC, 0, MINC, 0, MAXC, 0, MINC, 0, MAXC, 0, MINC, 0},
                                   1'b0, 0});
        rows.insert(rows.size(), '{'{-1, 1, -1, 1, -1, 1, -1, -1, 1, 1, 1, -1}, 1'b0, 0});
        rows.insert(rows.size(), '{'{8191, 0, 0, 0, 0, 0, 0, 8192, 0, 0, 8192, 8192},
                                   1'b0, 0});
        rows.insert(rows.size(), '{'{100, 200, 300, 484, 200, 300, 600, 550, 300,
                                     700, 600, 650}, 1'b0, 0});
        rows.insert(rows.size(), '{'{MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MINC, MAXC,
                                     MINC, MAXC, MINC}, 1'b0, 0});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            row = rows[i];
            send_item(pack_points(row.pt), row.known, 16'(row.torsion));
        end

        for (int n = 0; n < NUM_ITEMS; n++)
        begin
            // A stretch with no idling on either side.
            in_idle_en  = !(n >= 250 && n < 400);
            out_idle_en = in_idle_en;
            // Hold the output off while items keep coming, so the pipeline fills.
            if (n == 450)
                hold_req = 1'b1;
            // Let everything drain before carrying on.
            if (n == 600)
            begin
                s_tvalid <= 1'b0;
                wait (torsion_q.size() == 0);
                @(posedge clk);
            end
            send_item(random_quad(), 1'b0, 16'd0);
        end
        s_tvalid <= 1'b0;

        wait (torsion_q.size() == 0);
        repeat (LAT + 10) @(posedge clk);
        $display("Sent %0d quadruples (directed corners, bond chains, raw and degenerate);",
                 sent);
        $display("checked %0d torsion results under random and long back-pressure.",
                 checked);
        if (errors == 0 && torsion_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
